// ===== rtl/tom_pkg.sv =====
// ----------------------------------------------------------------------------
// tom_pkg
// Shared widths, reset values and codes for the tile occupancy map.
// ----------------------------------------------------------------------------
package tom_pkg;

  localparam int COORD_W   = 16;
  localparam int TS_W      = 9;
  localparam int VP_W      = 13;
  localparam int DVD_W     = 14;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;
  localparam int NUM_DIV   = 4;

  localparam int MAX_TILES_X_DEF = 64;
  localparam int MAX_TILES_Y_DEF = 64;

  localparam logic [TS_W-1:0] TS_RESET = 9'd16;
  localparam logic [VP_W-1:0] VP_RESET = 13'd1024;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_MARK  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_EDGE = 2'd0,
    REG_VP_WIDTH  = 2'd1,
    REG_VP_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ROWS,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/tom_div.sv =====
// ----------------------------------------------------------------------------
// tom_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tom_div #(
  parameter int NW = tom_pkg::DVD_W,
  parameter int DW = tom_pkg::TS_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [NW-1:0] work;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;
  logic          fits;

  always_comb begin
    shifted = {rem, work[NW-1]};
    fits    = shifted >= {1'b0, dsr};
    trial   = shifted - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CW'(1));
      if (start) begin
        cnt <= CW'(NW);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (cnt != '0) begin
      work <= {work[NW-2:0], fits};
      rem  <= fits ? trial[DW-1:0] : shifted[DW-1:0];
    end
  end

  assign quotient = work;

endmodule

// ===== rtl/tile_occupancy_map.sv =====
// ----------------------------------------------------------------------------
// tile_occupancy_map
// A clear runs the tile-size divider; a mark or query also sweeps each
// covered tile row; rejected, empty or unknown items skip both.
// One item is in work at a time; the tile-size divider and the
// one-row-per-cycle read-modify-write of the row memory set the rate.
// Reset empties the map (row valid bits cleared), marks it invalid and loads
// tile size 16 and a 1024 x 1024 viewport.
// ----------------------------------------------------------------------------
module tile_occupancy_map #(
  parameter int MAX_TILES_X = tom_pkg::MAX_TILES_X_DEF,
  parameter int MAX_TILES_Y = tom_pkg::MAX_TILES_Y_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // x_start, y_start, x_end, y_end (16 bits each, from the lowest bit up)
  input  logic [4*tom_pkg::COORD_W-1:0]  s_tdata,
  // mode
  input  logic [tom_pkg::MODE_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // region_occupied, then zero fill
  output logic [7:0]                     m_tdata,
  input  logic                           cfg_wr_en,
  input  logic [tom_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tom_pkg::VP_W-1:0]       cfg_data
);

  localparam int CW  = tom_pkg::COORD_W;
  localparam int SW  = CW + 1;
  localparam int DV  = tom_pkg::DVD_W;
  localparam int ND  = tom_pkg::NUM_DIV;
  localparam int XAW = (MAX_TILES_X > 1) ? $clog2(MAX_TILES_X) : 1;
  localparam int YAW = (MAX_TILES_Y > 1) ? $clog2(MAX_TILES_Y) : 1;
  localparam int XCW = $clog2(MAX_TILES_X + 1);
  localparam int YCW = $clog2(MAX_TILES_Y + 1);
  localparam logic signed [SW-1:0] ONE_S = SW'(1);

  // Configuration registers
  logic [tom_pkg::TS_W-1:0] tile_edge;
  logic [tom_pkg::VP_W-1:0] vp_width;
  logic [tom_pkg::VP_W-1:0] vp_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_edge <= tom_pkg::TS_RESET;
      vp_width  <= tom_pkg::VP_RESET;
      vp_height <= tom_pkg::VP_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tom_pkg::REG_TILE_EDGE: tile_edge <= cfg_data[tom_pkg::TS_W-1:0];
        tom_pkg::REG_VP_WIDTH:  vp_width  <= cfg_data;
        tom_pkg::REG_VP_HEIGHT: vp_height <= cfg_data;
        default: ;
      endcase
    end
  end

  tom_pkg::state_t state, state_next;

  logic [tom_pkg::MODE_W-1:0] mode_r;
  logic signed [CW-1:0]       xs_r, ys_r, xe_r, ye_r;

  logic           map_valid;
  logic [XCW-1:0] tiles_across;
  logic [YCW-1:0] tiles_down;

  logic [MAX_TILES_X-1:0] tile_mem [MAX_TILES_Y];
  logic [MAX_TILES_Y-1:0] row_vld;
  logic [MAX_TILES_X-1:0] mem_q;
  logic [YAW-1:0]         rd_addr;
  logic                   rd_ok;
  logic                   rd_v;
  logic [MAX_TILES_X-1:0] row_data;
  logic [MAX_TILES_X-1:0] mask;
  logic                   wr_en;

  logic [XAW-1:0] tx_lo, tx_hi;
  logic [YAW-1:0] ty_cur, ty_last;
  logic           hit;

  logic             div_start;
  logic [DV-1:0]    dvd [ND];
  logic [DV-1:0]    quo [ND];
  logic [ND-1:0]    div_done;
  logic             div_all_done;

  logic signed [SW-1:0] xs_e, ys_e, xe_e, ye_e, vw_e, vh_e;
  logic signed [SW-1:0] xs_c, ys_c, xe_c, ye_c, x_last, y_last;
  logic [DV-1:0]        w_round, h_round;
  logic                 grid_ok, cfg_zero, mark_reject, query_empty;
  logic                 is_clear, is_mark, is_query;
  logic                 load_out;

  logic [DV-1:0]  ta_m1, td_m1;
  logic [XAW-1:0] tx0, tx1;
  logic [YAW-1:0] ty0, ty1;

  assign is_clear = (mode_r == tom_pkg::MODE_CLEAR);
  assign is_mark  = (mode_r == tom_pkg::MODE_MARK);
  assign is_query = (mode_r == tom_pkg::MODE_QUERY);

  // Clamp the rectangle to the viewport. An inverted mark still covers the
  // pixel at its clamped start, so its last pixel never goes below the start.
  always_comb begin
    xs_e = SW'(xs_r);
    ys_e = SW'(ys_r);
    xe_e = SW'(xe_r);
    ye_e = SW'(ye_r);
    vw_e = signed'(SW'(vp_width));
    vh_e = signed'(SW'(vp_height));
    xs_c = (xs_e < 0) ? '0 : xs_e;
    ys_c = (ys_e < 0) ? '0 : ys_e;
    xe_c = (xe_e > vw_e) ? vw_e : xe_e;
    ye_c = (ye_e > vh_e) ? vh_e : ye_e;
    x_last = (xe_c <= xs_c) ? xs_c : xe_c - ONE_S;
    y_last = (ye_c <= ys_c) ? ys_c : ye_c - ONE_S;
    query_empty = (xs_c >= xe_c) || (ys_c >= ye_c);
    mark_reject = (xe_e <= 0) || (ye_e <= 0) || (xs_e >= vw_e) || (ys_e >= vh_e);
    cfg_zero = (tile_edge == '0) || (vp_width == '0) || (vp_height == '0);
    grid_ok  = map_valid && (tile_edge != '0) && (tiles_across != '0) &&
               (tiles_down != '0);
    w_round = DV'(vp_width) + DV'(tile_edge) - DV'(1);
    h_round = DV'(vp_height) + DV'(tile_edge) - DV'(1);
  end

  always_comb begin
    dvd[0] = is_clear ? w_round : DV'(xs_c[tom_pkg::VP_W-1:0]);
    dvd[1] = DV'(x_last[tom_pkg::VP_W-1:0]);
    dvd[2] = is_clear ? h_round : DV'(ys_c[tom_pkg::VP_W-1:0]);
    dvd[3] = DV'(y_last[tom_pkg::VP_W-1:0]);
  end

  for (genvar g = 0; g < ND; g++) begin : g_div
    tom_div #(
      .NW(DV),
      .DW(tom_pkg::TS_W)
    ) u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (dvd[g]),
      .divisor  (tile_edge),
      .done     (div_done[g]),
      .quotient (quo[g])
    );
  end

  assign div_all_done = &div_done;

  // Pixel quotients become tile indices, saturated at the last tile.
  always_comb begin
    ta_m1 = DV'(tiles_across) - DV'(1);
    td_m1 = DV'(tiles_down) - DV'(1);
    tx0 = (quo[0] > ta_m1) ? ta_m1[XAW-1:0] : quo[0][XAW-1:0];
    tx1 = (quo[1] > ta_m1) ? ta_m1[XAW-1:0] : quo[1][XAW-1:0];
    ty0 = (quo[2] > td_m1) ? td_m1[YAW-1:0] : quo[2][YAW-1:0];
    ty1 = (quo[3] > td_m1) ? td_m1[YAW-1:0] : quo[3][YAW-1:0];
  end

  always_comb begin
    for (int i = 0; i < MAX_TILES_X; i++) begin
      mask[i] = (XAW'(i) >= tx_lo) && (XAW'(i) <= tx_hi);
    end
  end

  assign load_out = (state == tom_pkg::ST_DONE) && (!m_tvalid || m_tready);
  assign s_tready = (state == tom_pkg::ST_IDLE);
  assign row_data = rd_ok ? mem_q : '0;
  assign wr_en    = rd_v && is_mark;

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      tom_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tom_pkg::ST_PREP;
      end
      tom_pkg::ST_PREP: begin
        state_next = tom_pkg::ST_DONE;
        case (mode_r)
          tom_pkg::MODE_CLEAR: begin
            if (!cfg_zero) begin
              div_start  = 1'b1;
              state_next = tom_pkg::ST_DIV;
            end
          end
          tom_pkg::MODE_MARK: begin
            if (grid_ok && !cfg_zero && !mark_reject) begin
              div_start  = 1'b1;
              state_next = tom_pkg::ST_DIV;
            end
          end
          tom_pkg::MODE_QUERY: begin
            if (grid_ok && !query_empty) begin
              div_start  = 1'b1;
              state_next = tom_pkg::ST_DIV;
            end
          end
          default: ;
        endcase
      end
      tom_pkg::ST_DIV: begin
        if (div_all_done) begin
          state_next = is_clear ? tom_pkg::ST_DONE : tom_pkg::ST_ROWS;
        end
      end
      tom_pkg::ST_ROWS: begin
        if (ty_cur == ty_last) state_next = tom_pkg::ST_DRAIN;
      end
      tom_pkg::ST_DRAIN: state_next = tom_pkg::ST_DONE;
      tom_pkg::ST_DONE: begin
        if (load_out) state_next = tom_pkg::ST_IDLE;
      end
      default: state_next = tom_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tom_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mode_r <= s_tuser;
      xs_r   <= signed'(s_tdata[CW-1:0]);
      ys_r   <= signed'(s_tdata[2*CW-1:CW]);
      xe_r   <= signed'(s_tdata[3*CW-1:2*CW]);
      ye_r   <= signed'(s_tdata[4*CW-1:3*CW]);
    end
  end

  // Map state: grid, valid flag and one valid bit per row. A row whose bit
  // is clear reads as all zeros, so a clear only drops the valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid    <= 1'b0;
      tiles_across <= '0;
      tiles_down   <= '0;
      row_vld      <= '0;
      rd_v         <= 1'b0;
    end else begin
      rd_v <= (state == tom_pkg::ST_ROWS);
      if (state == tom_pkg::ST_PREP && is_clear) begin
        row_vld <= '0;
        if (cfg_zero) begin
          map_valid    <= 1'b0;
          tiles_across <= '0;
          tiles_down   <= '0;
        end
      end else if (wr_en) begin
        row_vld[rd_addr] <= 1'b1;
      end
      if (state == tom_pkg::ST_DIV && div_all_done && is_clear) begin
        map_valid    <= 1'b1;
        tiles_across <= (quo[0] >= DV'(MAX_TILES_X)) ? XCW'(MAX_TILES_X)
                                                     : quo[0][XCW-1:0];
        tiles_down   <= (quo[2] >= DV'(MAX_TILES_Y)) ? YCW'(MAX_TILES_Y)
                                                     : quo[2][YCW-1:0];
      end
    end
  end

  // Row sweep and query accumulation.
  always_ff @(posedge clk) begin
    if (state == tom_pkg::ST_PREP) begin
      hit <= is_query && !grid_ok;
    end else if (rd_v && is_query) begin
      hit <= hit | (|(row_data & mask));
    end
    if (state == tom_pkg::ST_DIV && div_all_done) begin
      tx_lo   <= tx0;
      tx_hi   <= tx1;
      ty_cur  <= ty0;
      ty_last <= ty1;
    end else if (state == tom_pkg::ST_ROWS && ty_cur != ty_last) begin
      ty_cur <= ty_cur + YAW'(1);
    end
  end

  // Row memory: one read and one write port. Reads walk the rows in order,
  // so the write-back, in the cycle after the read, never hits the row being read.
  always_ff @(posedge clk) begin
    if (state == tom_pkg::ST_ROWS) begin
      mem_q   <= tile_mem[ty_cur];
      rd_ok   <= row_vld[ty_cur];
      rd_addr <= ty_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tile_mem[rd_addr] <= row_data | mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {7'b0, hit};
    end
  end

endmodule

// ===== tb/tile_occupancy_map_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_occupancy_map_tb
// Self-checking bench for the tile occupancy map. A short list of directed
// items walks through the corner cases first: queries before the first clear,
// marks that fall off screen, inverted rectangles, and extreme coordinates.
// After that, random phases run with different tile sizes and viewports.
// Each item that the block accepts also runs through a bench-side model of
// the tile bitmap, and every returned item is compared with what that model
// predicted or, for a typed directed item, with the flag listed for it.
// ----------------------------------------------------------------------------
module tile_occupancy_map_tb;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 500;
  localparam int PHASE_ITEMS    = 45;
  localparam int FIXED_PHASES   = 6;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int NUM_DIRECTED   = 24;
  localparam logic [tom_pkg::MODE_W-1:0] MODE_UNKNOWN = 2'd3;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [4*tom_pkg::COORD_W-1:0]   s_tdata;
  logic [tom_pkg::MODE_W-1:0]      s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  logic [7:0]                      m_tdata;
  logic                            cfg_wr_en;
  logic [tom_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [tom_pkg::VP_W-1:0]        cfg_data;

  tile_occupancy_map dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  typedef struct {
    logic [tom_pkg::MODE_W-1:0] mode;
    int                         xs;
    int                         ys;
    int                         xe;
    int                         ye;
    bit                         typed;
    bit                         occupied;
  } directed_item_t;

  typedef struct {
    int seq;
    bit occupied;
  } pending_t;

  // Expected occupancy flags, oldest first.
  pending_t occupancy_expected [$];

  // Bench copy of the tile bitmap and the registers.
  logic [63:0] tile_bits [tom_pkg::MAX_TILES_Y_DEF];
  bit          map_live;
  int          grid_w;
  int          grid_h;
  int          cur_tile;
  int          cur_vw;
  int          cur_vh;

  int error_count;
  int items_sent;
  int results_seen;
  int cycle_count;
  int clears_sent, marks_sent, queries_sent, unknown_sent, occupied_predicted;
  int settings_used;
  int source_run;
  int sink_run;

  directed_item_t directed_items [NUM_DIRECTED] = '{
    '{tom_pkg::MODE_QUERY, 0, 0, 16, 16, 1'b1, 1'b1},
    '{tom_pkg::MODE_MARK,  0, 0, 1024, 1024, 1'b1, 1'b0},
    '{MODE_UNKNOWN,        0, 0, 1024, 1024, 1'b1, 1'b0},
    '{tom_pkg::MODE_CLEAR, 0, 0, 0, 0, 1'b1, 1'b0},
    '{tom_pkg::MODE_QUERY, 0, 0, 1024, 1024, 1'b1, 1'b0},
    '{tom_pkg::MODE_MARK,  -32768, -32768, 32767, 32767, 1'b1, 1'b0},
    '{tom_pkg::MODE_QUERY, -32768, -32768, 32767, 32767, 1'b1, 1'b1},
    '{tom_pkg::MODE_CLEAR, 0, 0, 0, 0, 1'b1, 1'b0},
    '{tom_pkg::MODE_QUERY, 0, 0, 1024, 1024, 1'b1, 1'b0},
    '{tom_pkg::MODE_MARK,  -100, -100, 0, 50, 1'b1, 1'b0},
    '{tom_pkg::MODE_MARK,  1024, 0, 1100, 10, 1'b1, 1'b0},
    '{tom_pkg::MODE_MARK,  32767, 32767, -32768, -32768, 1'b1, 1'b0},
    '{tom_pkg::MODE_QUERY, 0, 0, 1024, 1024, 1'b1, 1'b0},
    '{tom_pkg::MODE_MARK,  500, 500, 400, 400, 1'b1, 1'b0},
    '{tom_pkg::MODE_QUERY, 496, 496, 512, 512, 1'b0, 1'b0},
    '{tom_pkg::MODE_QUERY, 2000, 0, 3000, 100, 1'b1, 1'b0},
    '{tom_pkg::MODE_QUERY, 10, 10, 5, 5, 1'b1, 1'b0},
    '{tom_pkg::MODE_QUERY, -32768, -32768, -1, -1, 1'b1, 1'b0},
    '{tom_pkg::MODE_MARK,  1023, 1023, 1024, 1024, 1'b1, 1'b0},
    '{tom_pkg::MODE_QUERY, 1008, 1008, 32767, 32767, 1'b0, 1'b0},
    '{tom_pkg::MODE_QUERY, 0, 0, 496, 496, 1'b0, 1'b0},
    '{tom_pkg::MODE_MARK,  0, 0, 1, 1, 1'b1, 1'b0},
    '{tom_pkg::MODE_QUERY, 0, 0, 1, 1, 1'b0, 1'b0},
    '{MODE_UNKNOWN,        -1, -1, -1, -1, 1'b1, 1'b0}
  };

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int tiles_for(int pixels, int cap);
    int n;
    n = (pixels + cur_tile - 1) / cur_tile;
    return (n > cap) ? cap : n;
  endfunction

  function automatic logic [63:0] column_mask(int lo, int hi);
    int n;
    logic [63:0] m;
    n = hi - lo + 1;
    m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    return m << lo;
  endfunction

  // Turns a clamped pixel rectangle into an inclusive tile range.
  function automatic void tile_span(input int xs, ys, xe, ye,
                                    output int tx0, tx1, ty0, ty1);
    tx0 = clamp_int(xs / cur_tile, 0, grid_w - 1);
    tx1 = clamp_int((xe - 1) / cur_tile, tx0, grid_w - 1);
    ty0 = clamp_int(ys / cur_tile, 0, grid_h - 1);
    ty1 = clamp_int((ye - 1) / cur_tile, ty0, grid_h - 1);
  endfunction

  // Applies one item to the bench copy of the map and returns the flag
  // the block should send back.
  function automatic bit predict_occupancy(logic [tom_pkg::MODE_W-1:0] md,
                                           logic [15:0] xs_f, logic [15:0] ys_f,
                                           logic [15:0] xe_f, logic [15:0] ye_f);
    int xs, ys, xe, ye, tx0, tx1, ty0, ty1;
    logic [63:0] m;
    bit occ;
    xs = $signed(xs_f);
    ys = $signed(ys_f);
    xe = $signed(xe_f);
    ye = $signed(ye_f);
    occ = 1'b0;
    case (md)
      tom_pkg::MODE_CLEAR: begin
        for (int r = 0; r < tom_pkg::MAX_TILES_Y_DEF; r++) tile_bits[r] = '0;
        if (cur_tile == 0 || cur_vw == 0 || cur_vh == 0) begin
          map_live = 1'b0;
          grid_w = 0;
          grid_h = 0;
        end else begin
          grid_w = tiles_for(cur_vw, tom_pkg::MAX_TILES_X_DEF);
          grid_h = tiles_for(cur_vh, tom_pkg::MAX_TILES_Y_DEF);
          map_live = 1'b1;
        end
      end
      tom_pkg::MODE_MARK: begin
        if (map_live && cur_tile != 0 && cur_vw != 0 && cur_vh != 0 &&
            grid_w != 0 && grid_h != 0 &&
            xe > 0 && ye > 0 && xs < cur_vw && ys < cur_vh) begin
          // An empty or inverted rectangle still covers its clamped start.
          xs = clamp_int(xs, 0, cur_vw - 1);
          xe = clamp_int(xe, xs + 1, cur_vw);
          ys = clamp_int(ys, 0, cur_vh - 1);
          ye = clamp_int(ye, ys + 1, cur_vh);
          tile_span(xs, ys, xe, ye, tx0, tx1, ty0, ty1);
          m = column_mask(tx0, tx1);
          for (int ty = ty0; ty <= ty1; ty++) tile_bits[ty] |= m;
        end
      end
      tom_pkg::MODE_QUERY: begin
        if (!map_live || cur_tile == 0 || grid_w == 0 || grid_h == 0) begin
          occ = 1'b1;
        end else begin
          if (xs < 0) xs = 0;
          if (ys < 0) ys = 0;
          if (xe > cur_vw) xe = cur_vw;
          if (ye > cur_vh) ye = cur_vh;
          if (xs < xe && ys < ye) begin
            tile_span(xs, ys, xe, ye, tx0, tx1, ty0, ty1);
            m = column_mask(tx0, tx1);
            for (int ty = ty0; ty <= ty1; ty++)
              if ((tile_bits[ty] & m) != 0) occ = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return occ;
  endfunction

  // Either side mostly waits a random gap from $urandom_range, with occasional runs of no wait.
  function automatic int next_gap(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      run_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR: %s", msg);
  endtask

  // Entered and left at a rising edge; the item is taken at the last edge.
  task automatic send_item(input logic [tom_pkg::MODE_W-1:0] md,
                           input int xs, ys, xe, ye,
                           input bit typed, input bit typed_occ);
    int gap;
    logic [15:0] xs16, ys16, xe16, ye16;
    bit occ;
    pending_t p;
    xs16 = xs[15:0];
    ys16 = ys[15:0];
    xe16 = xe[15:0];
    ye16 = ye[15:0];
    gap = next_gap(source_run);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= md;
    s_tdata  <= {ye16, xe16, ys16, xs16};
    do @(posedge clk); while (!s_tready);
    occ = predict_occupancy(md, xs16, ys16, xe16, ye16);
    p.seq = items_sent;
    p.occupied = typed ? typed_occ : occ;
    occupancy_expected.push_back(p);
    items_sent++;
    case (md)
      tom_pkg::MODE_CLEAR: clears_sent++;
      tom_pkg::MODE_MARK:  marks_sent++;
      tom_pkg::MODE_QUERY: begin
        queries_sent++;
        if (occ) occupied_predicted++;
      end
      default:    unknown_sent++;
    endcase
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (occupancy_expected.size() > 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes the registers picked in sel, back to back, while the block is idle.
  task automatic apply_settings(input int ts, input int vw, input int vh,
                                input bit [2:0] sel);
    int vals [3];
    tom_pkg::cfg_reg_t which;
    vals[0] = ts;
    vals[1] = vw;
    vals[2] = vh;
    for (int r = 0; r < 3; r++) begin
      if (sel[r]) begin
        which = tom_pkg::cfg_reg_t'(r);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_data  <= vals[r][tom_pkg::VP_W-1:0];
        @(posedge clk);
        case (which)
          tom_pkg::REG_TILE_EDGE: cur_tile = vals[r] & 'h1FF;
          tom_pkg::REG_VP_WIDTH:  cur_vw   = vals[r] & 'h1FFF;
          tom_pkg::REG_VP_HEIGHT: cur_vh   = vals[r] & 'h1FFF;
          default: ;
        endcase
      end
    end
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  function automatic int pick_start(int extent);
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return extent - 2 + int'($urandom_range(0, 4));
      2: return -int'($urandom_range(1, 40));
      default: return $urandom_range(0, (extent > 0) ? extent - 1 : 0);
    endcase
  endfunction

  function automatic int pick_end(int start, int extent, int unit);
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 65535)) - 32768;
      1: return start - int'($urandom_range(0, 3));
      2: return extent + int'($urandom_range(0, 40));
      default: return start + 1 + int'($urandom_range(0, 2 * unit));
    endcase
  endfunction

  task automatic send_random_item();
    int pick, unit, xs, ys, xe, ye;
    logic [tom_pkg::MODE_W-1:0] md;
    unit = (cur_tile > 0) ? cur_tile : 16;
    pick = $urandom_range(0, 99);
    if (pick < 3)       md = tom_pkg::MODE_CLEAR;
    else if (pick < 5)  md = MODE_UNKNOWN;
    else if (pick < 50) md = tom_pkg::MODE_MARK;
    else                md = tom_pkg::MODE_QUERY;
    xs = pick_start(cur_vw);
    ys = pick_start(cur_vh);
    xe = pick_end(xs, cur_vw, unit);
    ye = pick_end(ys, cur_vh, unit);
    send_item(md, xs, ys, xe, ye, 1'b0, 1'b0);
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d items still pending", cycle_count,
             occupancy_expected.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : result_checker
    int gap;
    pending_t head;
    m_tready = 1'b0;
    sink_run = 0;
    do @(posedge clk); while (rst);
    forever begin
      gap = next_gap(sink_run);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      results_seen++;
      if (occupancy_expected.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
      end else begin
        head = occupancy_expected.pop_front();
        if (m_tdata[0] !== head.occupied)
          report_mismatch($sformatf("item %0d: region_occupied %b, expected %b",
                                    head.seq, m_tdata[0], head.occupied));
        if (m_tdata[7:1] !== 7'd0)
          report_mismatch($sformatf("item %0d: fill bits %b, expected zero",
                                    head.seq, m_tdata[7:1]));
      end
    end
  end

  initial begin : stimulus
    int phase, ts, vw, vh, count;
    bit [2:0] sel;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    error_count = 0;
    items_sent = 0;
    results_seen = 0;
    source_run = 0;
    for (int r = 0; r < tom_pkg::MAX_TILES_Y_DEF; r++) tile_bits[r] = '0;
    map_live = 1'b0;
    grid_w = 0;
    grid_h = 0;
    cur_tile = tom_pkg::TS_RESET;
    cur_vw = tom_pkg::VP_RESET;
    cur_vh = tom_pkg::VP_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_items[i])
      send_item(directed_items[i].mode, directed_items[i].xs, directed_items[i].ys,
                directed_items[i].xe, directed_items[i].ye,
                directed_items[i].typed, directed_items[i].occupied);

    phase = 0;
    while (items_sent < NUM_DIRECTED + RANDOM_ITEMS) begin
      // The sender holds off here until every result is back.
      wait_drained();
      sel = 3'b111;
      case (phase)
        0: begin ts = 1;   vw = 1;    vh = 1;    end
        1: begin ts = 256; vw = 4096; vh = 4096; end
        2: begin ts = 0;   vw = 1024; vh = 1024; end
        3: begin ts = 16;  vw = 0;    vh = 512;  end
        4: begin ts = 1;   vw = 4096; vh = 4096; end
        5: begin ts = 7;   vw = 100;  vh = 0;    end
        default: begin
          ts = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 256);
          vw = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4096);
          vh = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 4096);
          if ($urandom_range(0, 3) == 0) sel = 3'($urandom_range(1, 7));
        end
      endcase
      apply_settings(ts, vw, vh, sel);
      // Now and then the old grid is kept, so marks see new registers only.
      if (phase < FIXED_PHASES || $urandom_range(0, 7) != 0)
        send_item(tom_pkg::MODE_CLEAR, 0, 0, 0, 0, 1'b0, 1'b0);
      for (count = 0; count < PHASE_ITEMS; count++) begin
        send_random_item();
        if ($urandom_range(0, 49) == 0) wait_drained();
      end
      phase++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d items: %0d clears, %0d marks, %0d queries, %0d of unknown mode.",
             items_sent, clears_sent, marks_sent, queries_sent, unknown_sent);
    $display("%0d queries were predicted occupied, over %0d register settings.",
             occupied_predicted, settings_used);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
